// File: hw/rtl/mext_pkg.sv
// shared types and constants for the 3x3 matrix exponential block
`default_nettype none
package mext_pkg;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TERMS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd1;
  localparam int unsigned TERM_CAP = 128;
  localparam int unsigned K_W = 8;
  localparam int unsigned TOL_W = 31;

  // controller commands and datapath status
  typedef struct packed {
    logic load;
    logic mac_clr;
    logic mac_acc;
    logic div_start;
    logic div_store;
    logic commit;
    logic norm_clr;
    logic norm_step;
    logic [3:0] elem;
    logic [1:0] m;
  } mext_cmd_t;

  typedef struct packed {
    logic div_done;
    logic norm_above;
  } mext_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/mext_div.sv
// restoring divider for magnitudes, one quotient bit per cycle, rounded half away
`default_nettype none
module mext_div #(
  parameter int unsigned NUM_W = 72
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [NUM_W-1:0]     num_i,
  input  wire logic [mext_pkg::K_W:0] den_i,
  output logic                      done_o,
  output logic [NUM_W-1:0]          quo_o
);
  import mext_pkg::*;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  logic [NUM_W-1:0] n_q, n_d, q_q, q_d;
  logic [K_W+1:0]   r_q, r_d;
  logic [K_W:0]     d_q;
  logic [CNT_W-1:0] c_q, c_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [K_W+1:0]   sh;

  assign sh = {r_q[K_W:0], n_q[NUM_W-1]};

  always_comb begin
    n_d = n_q; q_d = q_q; r_d = r_q; c_d = c_q; busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      n_d = num_i + NUM_W'(den_i >> 1);
      q_d = '0; r_d = '0; c_d = CNT_W'(NUM_W); busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = n_q << 1;
      if (sh >= {1'b0, d_q}) begin
        r_d = sh - {1'b0, d_q};
        q_d = {q_q[NUM_W-2:0], 1'b1};
      end else begin
        r_d = sh;
        q_d = {q_q[NUM_W-2:0], 1'b0};
      end
      c_d = c_q - 1'b1;
      if (c_q == CNT_W'(1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; c_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; c_q <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; q_q <= q_d; r_q <= r_d;
    if (start_i) d_q <= den_i;
  end

  assign done_o = done_q;
  assign quo_o  = q_q;
endmodule
`default_nettype wire

// File: hw/rtl/mext_dp.sv
// datapath: matrix registers, shared multiply-accumulate, divider, sum and norm
`default_nettype none
module mext_dp #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mext_pkg::mext_cmd_t           cmd_i,
  input  wire logic [mext_pkg::K_W:0]        k_i,
  input  wire logic [mext_pkg::TOL_W-1:0]    tol_i,
  input  wire logic [9*ELEM_WIDTH-1:0]       a_i,
  output mext_pkg::mext_sts_t                sts_o,
  output logic [9*ELEM_WIDTH-1:0]            e_o,
  output logic                               ovf_o
);
  import mext_pkg::*;
  localparam int unsigned PW = 2 * ELEM_WIDTH;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned NW = ELEM_WIDTH + 2;
  localparam logic signed [ELEM_WIDTH-1:0] EMAX = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
  localparam logic signed [ELEM_WIDTH-1:0] EMIN = {1'b1, {(ELEM_WIDTH-1){1'b0}}};

  logic signed [ELEM_WIDTH-1:0] a_q [9];
  logic signed [ELEM_WIDTH-1:0] t_q [9];
  logic signed [ELEM_WIDTH-1:0] nt_q[9];
  logic signed [ELEM_WIDTH-1:0] e_q [9];
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_q;
  logic [NW-1:0] col_q, best_q;
  logic ovf_q, sign_q, prod_v_q;
  logic [1:0] row, col;
  logic signed [ELEM_WIDTH-1:0] top, opb;
  logic signed [AW-1:0] rnd;
  logic [AW-1:0] mag;
  logic div_done;
  logic [AW-1:0] quo;
  logic signed [AW:0] q_s;
  logic signed [ELEM_WIDTH-1:0] q_sat;
  logic q_ov;
  logic signed [ELEM_WIDTH:0] esum;
  logic [ELEM_WIDTH-1:0] absv;
  logic [NW-1:0] col_n;

  always_comb begin
    case (cmd_i.elem)
      4'd0: begin row = 2'd0; col = 2'd0; end
      4'd1: begin row = 2'd0; col = 2'd1; end
      4'd2: begin row = 2'd0; col = 2'd2; end
      4'd3: begin row = 2'd1; col = 2'd0; end
      4'd4: begin row = 2'd1; col = 2'd1; end
      4'd5: begin row = 2'd1; col = 2'd2; end
      4'd6: begin row = 2'd2; col = 2'd0; end
      4'd7: begin row = 2'd2; col = 2'd1; end
      4'd8: begin row = 2'd2; col = 2'd2; end
      default: begin row = 2'd0; col = 2'd0; end
    endcase
    top = t_q[4'(row) * 4'd3 + 4'(cmd_i.m)];
    opb = a_q[4'(cmd_i.m) * 4'd3 + 4'(col)];
  end

  // product rounded at the fraction point, ties up
  assign rnd = (acc_q + $signed(AW'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
  assign mag = rnd[AW-1] ? AW'(-rnd) : rnd;

  mext_div #(.NUM_W(AW)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(mag), .den_i(k_i),
    .done_o(div_done), .quo_o(quo)
  );

  always_comb begin
    q_s = sign_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    q_ov = 1'b0;
    q_sat = q_s[ELEM_WIDTH-1:0];
    if (q_s > (AW+1)'(EMAX)) begin q_sat = EMAX; q_ov = 1'b1; end
    else if (q_s < (AW+1)'(EMIN)) begin q_sat = EMIN; q_ov = 1'b1; end
  end

  assign esum = (ELEM_WIDTH+1)'(e_q[cmd_i.elem]) + (ELEM_WIDTH+1)'(nt_q[cmd_i.elem]);
  assign absv = t_q[cmd_i.elem][ELEM_WIDTH-1] ? ELEM_WIDTH'(-t_q[cmd_i.elem])
                                               : ELEM_WIDTH'(t_q[cmd_i.elem]);
  assign col_n = col_q + NW'(absv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q <= 1'b0; prod_v_q <= 1'b0;
    end else begin
      prod_v_q <= cmd_i.mac_acc;
      if (cmd_i.load) ovf_q <= 1'b0;
      else if (cmd_i.div_store && q_ov) ovf_q <= 1'b1;
      else if (cmd_i.commit && (esum > (ELEM_WIDTH+1)'(EMAX) ||
                                esum < (ELEM_WIDTH+1)'(EMIN))) ovf_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 9; i++) begin
        a_q[i] <= a_i[i*ELEM_WIDTH +: ELEM_WIDTH];
        t_q[i] <= (i % 4 == 0) ? ELEM_WIDTH'(1) << FRAC_BITS : '0;
        e_q[i] <= (i % 4 == 0) ? ELEM_WIDTH'(1) << FRAC_BITS : '0;
      end
      best_q <= NW'(1) << FRAC_BITS;
    end
    if (cmd_i.mac_clr) acc_q <= '0;
    else if (prod_v_q) acc_q <= acc_q + AW'(prod_q);
    if (cmd_i.mac_acc) prod_q <= top * opb;
    if (cmd_i.div_start) sign_q <= rnd[AW-1];
    if (cmd_i.div_store) nt_q[cmd_i.elem] <= q_sat;
    if (cmd_i.commit) begin
      t_q[cmd_i.elem] <= nt_q[cmd_i.elem];
      if (esum > (ELEM_WIDTH+1)'(EMAX)) e_q[cmd_i.elem] <= EMAX;
      else if (esum < (ELEM_WIDTH+1)'(EMIN)) e_q[cmd_i.elem] <= EMIN;
      else e_q[cmd_i.elem] <= esum[ELEM_WIDTH-1:0];
    end
    if (cmd_i.norm_clr) begin
      best_q <= '0; col_q <= '0;
    end else if (cmd_i.norm_step) begin
      if (row == 2'd2) begin
        col_q <= '0;
        if (col_n > best_q) best_q <= col_n;
      end else col_q <= col_n;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) e_o[i*ELEM_WIDTH +: ELEM_WIDTH] = e_q[i];
  end
  assign ovf_o = ovf_q;
  assign sts_o.div_done = div_done;
  assign sts_o.norm_above = best_q > NW'(tol_i);
endmodule
`default_nettype wire

// File: hw/rtl/mext_ctrl.sv
// controller: sequences products, divides, sums and the norm for each term
`default_nettype none
module mext_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  input  wire logic [mext_pkg::K_W-1:0]   lim_i,
  input  wire mext_pkg::mext_sts_t        sts_i,
  output mext_pkg::mext_cmd_t             cmd_o,
  output logic [mext_pkg::K_W:0]          k_o,
  output logic [mext_pkg::K_W-1:0]        terms_o
);
  import mext_pkg::*;
  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_CHECK = 8'b00000010, S_MAC = 8'b00000100,
    S_FIN  = 8'b00001000, S_DIV   = 8'b00010000, S_ADD = 8'b00100000,
    S_NORM = 8'b01000000, S_OUT   = 8'b10000000
  } state_e;
  state_e st_q, st_d;
  logic [3:0] el_q, el_d;
  logic [2:0] m_q, m_d;
  logic [K_W-1:0] k_q, k_d;
  logic [K_W-1:0] lim;

  assign lim = (lim_i > K_W'(TERM_CAP)) ? K_W'(TERM_CAP) : lim_i;

  always_comb begin
    st_d = st_q; el_d = el_q; m_d = m_q; k_d = k_q;
    cmd_o = '0;
    cmd_o.elem = el_q;
    cmd_o.m = m_q[1:0];
    case (st_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1; k_d = '0; st_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.norm_above && k_q < lim) begin
          el_d = '0; m_d = '0; cmd_o.mac_clr = 1'b1; st_d = S_MAC;
        end else st_d = S_OUT;
      end
      S_MAC: begin
        cmd_o.mac_acc = 1'b1; m_d = m_q + 1'b1;
        if (m_q == 3'd2) st_d = S_FIN;
      end
      S_FIN: begin
        m_d = m_q + 1'b1;
        if (m_q == 3'd4) begin cmd_o.div_start = 1'b1; st_d = S_DIV; end
      end
      S_DIV: if (sts_i.div_done) begin
        cmd_o.div_store = 1'b1; m_d = '0; cmd_o.mac_clr = 1'b1;
        if (el_q == 4'd8) begin el_d = '0; st_d = S_ADD; end
        else begin el_d = el_q + 1'b1; st_d = S_MAC; end
      end
      S_ADD: begin
        cmd_o.commit = 1'b1;
        if (el_q == 4'd8) begin
          el_d = '0; cmd_o.norm_clr = 1'b1; k_d = k_q + 1'b1; st_d = S_NORM;
        end else el_d = el_q + 1'b1;
      end
      S_NORM: begin
        // column-major walk
        cmd_o.norm_step = 1'b1;
        cmd_o.elem = 4'(el_q[1:0]) * 4'd3 + 4'(el_q[3:2]);
        if (el_q == {2'd2, 2'd2}) begin el_d = '0; st_d = S_CHECK; end
        else if (el_q[1:0] == 2'd2) el_d = {el_q[3:2] + 2'd1, 2'd0};
        else el_d = el_q + 1'b1;
      end
      S_OUT: if (!out_stall_i) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE; el_q <= '0; m_q <= '0; k_q <= '0;
    end else begin
      st_q <= st_d; el_q <= el_d; m_q <= m_d; k_q <= k_d;
    end
  end

  assign in_stall_o  = st_q != S_IDLE;
  assign out_valid_o = st_q == S_OUT;
  assign k_o = {1'b0, k_q} + 1'b1;
  assign terms_o = k_q;
endmodule
`default_nettype wire

// File: hw/rtl/matrix_exponential_taylor_3x3.sv
// top level of the 3x3 matrix exponential by Taylor series
//  channel | handshake              | payload
//  in      | in_valid_i/in_stall_o   | a_00_i .. a_22_i
//  out     | out_valid_o/out_stall_i | e_00_o .. e_22_o, overflow_o, terms_used_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// each term runs its 9 elements one after another through the one shared
// multiplier and bit-serial divider, plus check, sum and norm; up to 128 terms.
// reset returns max_terms to 128 and tolerance to 0; no memory clearing.
// a new matrix is taken only when idle; the result holds while out is stalled.
`default_nettype none
module matrix_exponential_taylor_3x3 #(
  parameter int unsigned ELEM_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic signed [ELEM_WIDTH-1:0] a_00_i, a_01_i, a_02_i,
  input  wire logic signed [ELEM_WIDTH-1:0] a_10_i, a_11_i, a_12_i,
  input  wire logic signed [ELEM_WIDTH-1:0] a_20_i, a_21_i, a_22_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic signed [ELEM_WIDTH-1:0] e_00_o, e_01_o, e_02_o,
  output logic signed [ELEM_WIDTH-1:0] e_10_o, e_11_o, e_12_o,
  output logic signed [ELEM_WIDTH-1:0] e_20_o, e_21_o, e_22_o,
  output logic      overflow_o,
  output logic [7:0] terms_used_o,
  input  wire logic cfg_valid_i,
  output logic      cfg_ready_o,
  input  wire logic [mext_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  import mext_pkg::*;
  logic [K_W-1:0] max_terms_q;
  logic [TOL_W-1:0] tol_q;
  mext_cmd_t cmd;
  mext_sts_t sts;
  logic [K_W:0] k;
  logic [9*ELEM_WIDTH-1:0] a_v, e_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_terms_q <= K_W'(TERM_CAP); tol_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_TERMS: max_terms_q <= cfg_data_i[K_W-1:0];
        CFG_TOLERANCE: tol_q <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end
  assign cfg_ready_o = 1'b1;

  assign a_v = {a_22_i, a_21_i, a_20_i, a_12_i, a_11_i, a_10_i, a_02_i, a_01_i, a_00_i};
  assign {e_22_o, e_21_o, e_20_o, e_12_o, e_11_o, e_10_o, e_02_o, e_01_o, e_00_o} = e_v;

  mext_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .lim_i(max_terms_q), .sts_i(sts), .cmd_o(cmd), .k_o(k), .terms_o(terms_used_o)
  );

  mext_dp #(.ELEM_WIDTH(ELEM_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .k_i(k), .tol_i(tol_q), .a_i(a_v),
    .sts_o(sts), .e_o(e_v), .ovf_o(overflow_o)
  );

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(e_00_o) && $stable(terms_used_o))
    else $error("result changed while stalled");
  a_terms_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> terms_used_o <= 8'd128) else $error("terms above cap");
`endif
endmodule
`default_nettype wire
